[hdl/fir_filter_circular_history_defines.svh]
// Assertion macros for the verification checker of the FIR filter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define FIR_CIRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define FIR_CIRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fir_circ_pkg.sv]
package fir_circ_pkg;

  // Fixed field widths of the transaction and configuration formats, and the minimum tap count.
  localparam int TAP_BITS      = 18;
  localparam int TAP_IDX_BITS  = 10;
  localparam int TC_BITS       = 10;
  localparam int REQ_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;
  localparam int MIN_TAPS      = 3;

  // Request codes.
  localparam logic [REQ_BITS-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_TAP    = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BYPASS    = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cnt_zero;    // restart the shared address counter
    logic sweep;       // write zeros into the history at the counter
    logic sweep_taps;  // also write zeros into the tap store
    logic start;       // store the new sample and set up the read pointer
    logic issue;       // read one tap and one history entry
    logic latch;       // hold the incoming sample for pass-through
    logic tap_wr;      // write one coefficient
    logic out_load;    // load the output register
    logic out_byp;     // output register takes the held sample
  } fir_circ_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bypass;
    logic sweep_last;
    logic issue_last;
    logic pipe_busy;
  } fir_circ_stat_t;

endpackage

[hdl/fir_circ_ram.sv]
module fir_circ_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/fir_circ_ctrl.sv]
module fir_circ_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [fir_circ_pkg::REQ_BITS-1:0]    in_req_type,
  output logic                                 in_ready,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  input  fir_circ_pkg::fir_circ_stat_t         stat,
  output fir_circ_pkg::fir_circ_cmd_t          cmd
);

  import fir_circ_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MAC     = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_OUT_FIR = 3'd4;
  localparam logic [2:0] ST_OUT_BYP = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       init_r, init_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_taps = init_r;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_req_type)
            REQ_SAMPLE: begin
              if (stat.bypass) begin
                cmd.latch = 1'b1;
                state_nxt = ST_OUT_BYP;
              end else begin
                cmd.start    = 1'b1;
                cmd.cnt_zero = 1'b1;
                state_nxt    = ST_MAC;
              end
            end
            REQ_TAP: begin
              cmd.tap_wr = 1'b1;
            end
            REQ_CLEAR: begin
              cmd.cnt_zero = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_OUT_FIR;
        end
      end
      ST_OUT_FIR, ST_OUT_BYP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_byp  = (state_r == ST_OUT_BYP);
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the output side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/fir_circ_dp.sv]
module fir_circ_dp #(
  parameter int MAX_TAPS      = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int TAP_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [fir_circ_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fir_circ_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]             in_sample_in,
  input  logic [fir_circ_pkg::TAP_IDX_BITS-1:0]     in_tap_index,
  input  logic signed [fir_circ_pkg::TAP_BITS-1:0]  in_tap_value,
  output logic signed [SAMPLE_BITS-1:0]             out_sample_out,
  input  fir_circ_pkg::fir_circ_cmd_t               cmd,
  output fir_circ_pkg::fir_circ_stat_t              stat
);

  import fir_circ_pkg::*;

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int LW     = $clog2(MAX_TAPS + 1);
  localparam int IW     = (LW > TAP_IDX_BITS) ? LW : TAP_IDX_BITS;
  localparam int PW     = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W  = PW + AW;
  localparam int RW     = ACC_W + 1;
  localparam logic signed [RW-1:0] HALF   = RW'(1) << (TAP_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  // Increment a ring position, wrapping to zero at the ring length.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v,
                                             input logic [LW-1:0] lim);
    logic [LW-1:0] n;
    n = LW'(v) + LW'(1);
    return (n >= lim) ? '0 : n[AW-1:0];
  endfunction

  logic [TC_BITS-1:0]            tap_count_r;
  logic                          bypass_r;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic [AW-1:0]                 rp_r, rp_nxt;
  logic [AW-1:0]                 cnt_r, cnt_nxt;
  logic                          rd_v_r, prod_v_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic signed [SAMPLE_BITS-1:0] out_r;
  logic [IW-1:0]                 tc_ext;
  logic [IW-1:0]                 tidx_ext;
  logic [LW-1:0]                 len;
  logic [AW-1:0]                 head;
  logic                          hist_we, tap_we;
  logic [AW-1:0]                 hist_waddr, tap_waddr;
  logic [SAMPLE_BITS-1:0]        hist_wdata;
  logic [TAP_BITS-1:0]           tap_wdata;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic signed [TAP_BITS-1:0]    tap_rd;
  logic signed [RW-1:0]          rsum, rshift;
  logic signed [SAMPLE_BITS-1:0] rsat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TC_BITS'(MIN_TAPS);
      bypass_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAP_COUNT: tap_count_r <= cfg_data[TC_BITS-1:0];
        CFG_BYPASS:    bypass_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Ring length in use, clamped to the supported range.
  assign tc_ext = IW'(tap_count_r);
  assign len    = (tc_ext < IW'(MIN_TAPS)) ? LW'(MIN_TAPS) :
                  (tc_ext > IW'(MAX_TAPS)) ? LW'(MAX_TAPS) : LW'(tc_ext);

  assign head = wrap_inc(wp_r, len);

  // History writes: zeroing sweep or the incoming sample at the new head.
  assign hist_we    = cmd.sweep || cmd.start;
  assign hist_waddr = cmd.sweep ? cnt_r : head;
  assign hist_wdata = cmd.sweep ? '0 : in_sample_in;

  // Coefficient writes: zeroing sweep after reset or a tap-load transaction.
  assign tidx_ext  = IW'(in_tap_index);
  assign tap_we    = (cmd.sweep && cmd.sweep_taps) ||
                     (cmd.tap_wr && (tidx_ext < IW'(MAX_TAPS)));
  assign tap_waddr = cmd.sweep ? cnt_r : tidx_ext[AW-1:0];
  assign tap_wdata = cmd.sweep ? '0 : in_tap_value;

  fir_circ_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (cmd.issue),
    .raddr (rp_r),
    .rdata (hist_rd)
  );

  fir_circ_ram #(
    .WIDTH (TAP_BITS),
    .DEPTH (MAX_TAPS)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .re    (cmd.issue),
    .raddr (cnt_r),
    .rdata (tap_rd)
  );

  // Counter, read pointer and write position.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.sweep || cmd.issue) begin
      cnt_nxt = cnt_r + AW'(1);
    end

    rp_nxt = rp_r;
    if (cmd.start) begin
      rp_nxt = wrap_inc(head, len);
    end else if (cmd.issue) begin
      rp_nxt = wrap_inc(rp_r, len);
    end

    wp_nxt = wp_r;
    if (cmd.start) begin
      wp_nxt = head;
    end else if (cmd.sweep && stat.sweep_last) begin
      wp_nxt = AW'(MAX_TAPS - 1);
    end
  end

  // Multiply-accumulate pipeline: memory read, product, sum.
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rp_r     <= '0;
      wp_r     <= AW'(MAX_TAPS - 1);
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rp_r     <= rp_nxt;
      wp_r     <= wp_nxt;
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= hist_rd * tap_rd;
    acc_r  <= acc_nxt;
    if (cmd.latch) begin
      samp_r <= in_sample_in;
    end
  end

  // Round half up, drop the fraction bits and saturate.
  assign rsum   = RW'(acc_r) + HALF;
  assign rshift = rsum >>> TAP_FRAC_BITS;
  assign rsat   = (rshift > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] :
                  (rshift < SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] :
                  rshift[SAMPLE_BITS-1:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= cmd.out_byp ? samp_r : rsat;
    end
  end

  assign out_sample_out = out_r;

  assign stat.bypass     = bypass_r;
  assign stat.sweep_last = (cnt_r == AW'(MAX_TAPS - 1));
  assign stat.issue_last = (LW'(cnt_r) == (len - LW'(1)));
  assign stat.pipe_busy  = rd_v_r || prod_v_r;

endmodule

[hdl/fir_filter_circular_history.sv]
// Filtered sample: the taps in use are read one tap product per cycle and summed; the
// result is loaded into the output register once it is free, and the next transaction
// is taken after that load. Pass-through sample: the held sample is loaded the same
// way. Tap load: written on acceptance. Clear: a sweep of one history entry per cycle
// over all MAX_TAPS entries. Reset (rst_n low, synchronous): a sweep zeroes history
// and taps; no input is taken until it ends, configuration writes are taken.
module fir_filter_circular_history #(
  parameter int MAX_TAPS      = 1024,
  parameter int SAMPLE_BITS   = 16,
  parameter int TAP_FRAC_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [fir_circ_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fir_circ_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [fir_circ_pkg::REQ_BITS-1:0]         in_req_type,
  input  logic signed [SAMPLE_BITS-1:0]             in_sample_in,
  input  logic [fir_circ_pkg::TAP_IDX_BITS-1:0]     in_tap_index,
  input  logic signed [fir_circ_pkg::TAP_BITS-1:0]  in_tap_value,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [SAMPLE_BITS-1:0]             out_sample_out
);

  import fir_circ_pkg::*;

  fir_circ_cmd_t  cmd;
  fir_circ_stat_t stat;

  fir_circ_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  fir_circ_dp #(
    .MAX_TAPS      (MAX_TAPS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .TAP_FRAC_BITS (TAP_FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_in   (in_sample_in),
    .in_tap_index   (in_tap_index),
    .in_tap_value   (in_tap_value),
    .out_sample_out (out_sample_out),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

[hdl/fir_circ_checker.sv]
`include "fir_filter_circular_history_defines.svh"

module fir_circ_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                      clk,
  input logic                                      rst_n,
  input logic                                      in_valid,
  input logic                                      in_ready,
  input logic [fir_circ_pkg::REQ_BITS-1:0]         in_req_type,
  input logic                                      out_valid,
  input logic                                      out_ready,
  input logic signed [SAMPLE_BITS-1:0]             out_sample_out
);

  import fir_circ_pkg::*;

  logic in_xact;

  assign in_xact = in_valid && in_ready;

  // A stalled result holds its value.
  `FIR_CIRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_sample_out), "stalled result changed or dropped")

  // The clearing pass after reset keeps the input side closed.
  `FIR_CIRC_ASSERT_NOW(a_reset_sweep, $rose(rst_n), !in_ready,
    "input taken during the clearing pass after reset")

  // A sample or a clear closes the input side once it is accepted.
  `FIR_CIRC_ASSERT_NEXT(a_sample_busy, in_xact && in_req_type == REQ_SAMPLE,
    !in_ready, "input taken while a sample is in progress")
  `FIR_CIRC_ASSERT_NEXT(a_clear_busy, in_xact && in_req_type == REQ_CLEAR,
    !in_ready, "input taken while the history is being cleared")

  // A tap load finishes in its own cycle.
  `FIR_CIRC_ASSERT_NEXT(a_tap_ready, in_xact && in_req_type == REQ_TAP,
    in_ready, "block not ready after a tap load")

endmodule

bind fir_filter_circular_history fir_circ_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

[bench/fir_circ_tb_pkg.sv]
package fir_circ_tb_pkg;
  import fir_circ_pkg::*;

  localparam int HISTORY_DEPTH = 1024;
  localparam int SAMPLE_W      = 16;
  localparam int TAP_FRAC_W    = 16;

  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));

  // Codes that the design package leaves unnamed.
  localparam logic [REQ_BITS-1:0]     REQ_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

  // One input transaction, all fields carried whatever the request type.
  typedef struct {
    logic [REQ_BITS-1:0]            req;
    logic signed [SAMPLE_W-1:0]     sample;
    logic [TAP_IDX_BITS-1:0]        tap_idx;
    logic signed [TAP_BITS-1:0]     tap_val;
  } fir_request_t;

  // Tracks the filter state and the queue of output samples still owed.
  class filtered_sample_tracker;
    logic signed [SAMPLE_W-1:0] history [HISTORY_DEPTH];
    logic signed [TAP_BITS-1:0] coeffs [HISTORY_DEPTH];
    int                         newest_slot;
    logic [TC_BITS-1:0]         tap_count;
    logic                       bypass;
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                         mismatches;

    function new();
      tap_count = TC_BITS'(MIN_TAPS);
      bypass = 1'b1;
      foreach (coeffs[i]) coeffs[i] = '0;
      clear_history();
      mismatches = 0;
    endfunction

    // The history goes to zero and the next sample lands in slot zero.
    function void clear_history();
      foreach (history[i]) history[i] = '0;
      newest_slot = HISTORY_DEPTH - 1;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_TAP_COUNT: tap_count = data[TC_BITS-1:0];
        CFG_BYPASS:    bypass = data[0];
        default: ;
      endcase
    endfunction

    // Register value clamped to the range the filter can use.
    function int taps_in_use();
      int n;
      n = tap_count;
      if (n < MIN_TAPS) n = MIN_TAPS;
      if (n > HISTORY_DEPTH) n = HISTORY_DEPTH;
      return n;
    endfunction

    // Stores the sample in the ring and forms the rounded, saturated dot product.
    function logic signed [SAMPLE_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] s);
      int     len;
      int     slot;
      int     back;
      int     pos;
      int     i;
      longint acc;
      longint rounded;
      len = taps_in_use();
      slot = newest_slot + 1;
      if (slot >= len) slot = 0;
      history[slot] = s;
      newest_slot = slot;
      acc = 0;
      // Tap zero meets the oldest sample, the last tap the newest one.
      for (i = 0; i < len; i++) begin
        back = len - 1 - i;
        pos = (slot >= back) ? slot - back : slot + len - back;
        acc += longint'(coeffs[i]) * longint'(history[pos]);
      end
      rounded = (acc + (longint'(1) << (TAP_FRAC_W - 1))) >>> TAP_FRAC_W;
      if (rounded > SAMPLE_MAX) rounded = SAMPLE_MAX;
      if (rounded < SAMPLE_MIN) rounded = SAMPLE_MIN;
      return SAMPLE_W'(rounded);
    endfunction

    // Called for every input transaction at the edge where it is accepted.
    function void take_request(fir_request_t r);
      case (r.req)
        REQ_SAMPLE: begin
          if (bypass) expected_samples.push_back(r.sample);
          else expected_samples.push_back(filter_sample(r.sample));
        end
        REQ_TAP:   coeffs[r.tap_idx] = r.tap_val;
        REQ_CLEAR: clear_history();
        default: ;
      endcase
    endfunction

    // Called for every output transaction.
    function void compare_sample(logic signed [SAMPLE_W-1:0] got, time stamp);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        $display("%0d ns: sample_out %0d arrived with nothing expected", stamp, got);
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0d ns: sample_out expected %0d, actual %0d", stamp, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

[bench/tb_fir_filter_circular_history.sv]
module tb_fir_filter_circular_history;
  timeunit 1ns;
  timeprecision 1ps;

  import fir_circ_pkg::*;
  import fir_circ_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_PHASES     = 13;
  localparam int DRAIN_PHASE    = 7;

  // Tap count, bypass and number of counted transactions for each random phase.
  localparam int PHASE_TAPS [NUM_PHASES] = '{5, 0, 8, 31, 1023, 7, 2, 17, 6, 1, 64, 13, 1022};
  localparam bit PHASE_BYPASS [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 40, 50, 60, 10, 50, 40, 60, 50, 30, 40, 60, 8};

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [CFG_IDX_BITS-1:0]           cfg_index;
  logic [CFG_DATA_BITS-1:0]          cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic [REQ_BITS-1:0]               in_req_type;
  logic signed [SAMPLE_W-1:0]        in_sample_in;
  logic [TAP_IDX_BITS-1:0]           in_tap_index;
  logic signed [TAP_BITS-1:0]        in_tap_value;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]        out_sample_out;

  filtered_sample_tracker board;
  bit                     no_idle;
  int                     stall_cycles = 0;

  fir_filter_circular_history dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sample_in   (in_sample_in),
    .in_tap_index   (in_tap_index),
    .in_tap_value   (in_tap_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side: check each transaction, stall at random, and guard against hangs.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.compare_sample(out_sample_out, $time);
    end
    out_ready <= no_idle || ($urandom_range(99) >= 14);
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic fir_request_t mk(logic [REQ_BITS-1:0] req, int sample, int idx, int val);
    fir_request_t r;
    r.req = req;
    r.sample = SAMPLE_W'(sample);
    r.tap_idx = TAP_IDX_BITS'(idx);
    r.tap_val = TAP_BITS'(val);
    return r;
  endfunction

  // Mix of full-scale extremes, small values and anything at all.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    if (pick < 40) return SAMPLE_W'(int'($urandom_range(512)) - 256);
    return SAMPLE_W'($urandom);
  endfunction

  // Mostly modest taps so that the sums do not all saturate.
  function automatic logic signed [TAP_BITS-1:0] random_tap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
    if (pick < 60) return TAP_BITS'(int'($urandom_range(8192)) - 4096);
    return TAP_BITS'($urandom);
  endfunction

  function automatic fir_request_t random_request(int len);
    fir_request_t r;
    int           pick;
    pick = $urandom_range(99);
    r.sample = random_sample();
    r.tap_idx = TAP_IDX_BITS'($urandom_range(1023));
    r.tap_val = random_tap();
    if (pick < 70) begin
      r.req = REQ_SAMPLE;
    end else if (pick < 92) begin
      r.req = REQ_TAP;
      // Most loads go to taps that are in use.
      if ($urandom_range(3) != 0) r.tap_idx = TAP_IDX_BITS'($urandom_range(len - 1));
    end else if (pick < 97) begin
      r.req = REQ_CLEAR;
    end else begin
      r.req = REQ_UNUSED;
    end
    return r;
  endfunction

  // Presents one input transaction, with random idle cycles first.
  task automatic send(input fir_request_t r);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_sample_in <= r.sample;
    in_tap_index <= r.tap_idx;
    in_tap_value <= r.tap_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Waits out any clear sweep still running, then reprograms the filter.
  task automatic apply_setting(input int taps, input bit byp);
    drain();
    repeat (HISTORY_DEPTH + 8) @(posedge clk);
    write_reg(CFG_TAP_COUNT, CFG_DATA_BITS'(taps));
    write_reg(CFG_BYPASS, {9'($urandom_range(511)), byp});
    write_reg(CFG_SPARE_A, CFG_DATA_BITS'($urandom_range(1023)));
    write_reg(CFG_SPARE_B, CFG_DATA_BITS'($urandom_range(1023)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int           p;
    int           counted;
    bit           drained;
    fir_request_t r;
    board = new();
    no_idle = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_req_type <= '0;
    in_sample_in <= '0;
    in_tap_index <= '0;
    in_tap_value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Pass-through after reset, an unused request code, tap loads at the
    // field extremes and a clear.
    send(mk(REQ_SAMPLE, -32768, 0, 0));
    send(mk(REQ_SAMPLE, 32767, 0, 0));
    send(mk(REQ_UNUSED, -1, 1023, -1));
    send(mk(REQ_TAP, 0, 0, -131072));
    send(mk(REQ_TAP, 0, 1, 131071));
    send(mk(REQ_TAP, 0, 2, 65536));
    send(mk(REQ_TAP, 0, 1023, -1));
    send(mk(REQ_CLEAR, 0, 0, 0));

    // Three taps filtering: full scale both ways to hit saturation, then
    // rounding of exact halves after a clear.
    apply_setting(3, 1'b0);
    send(mk(REQ_SAMPLE, 32767, 0, 0));
    send(mk(REQ_SAMPLE, 32767, 0, 0));
    send(mk(REQ_SAMPLE, 32767, 0, 0));
    send(mk(REQ_SAMPLE, -32768, 0, 0));
    send(mk(REQ_SAMPLE, -32768, 0, 0));
    send(mk(REQ_CLEAR, 0, 0, 0));
    send(mk(REQ_TAP, 0, 2, 32768));
    send(mk(REQ_TAP, 0, 0, 0));
    send(mk(REQ_TAP, 0, 1, 0));
    send(mk(REQ_SAMPLE, 1, 0, 0));
    send(mk(REQ_SAMPLE, -1, 0, 0));
    send(mk(REQ_SAMPLE, 0, 0, 0));

    // Random phases over a spread of tap counts, including the clamped ones.
    for (p = 0; p < NUM_PHASES; p++) begin
      apply_setting(PHASE_TAPS[p], PHASE_BYPASS[p]);
      no_idle = (p == 2 || p == 3);
      counted = 0;
      drained = 1'b0;
      while (counted < PHASE_ITEMS[p]) begin
        if (p == DRAIN_PHASE && !drained && counted == PHASE_ITEMS[p] / 2) begin
          drain();
          drained = 1'b1;
        end
        r = random_request(board.taps_in_use());
        send(r);
        if (r.req != REQ_UNUSED) counted++;
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (HISTORY_DEPTH + 16) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
